// File: hdl/bul_pkg.sv
// shared types and constants for the bounded unique list
`default_nettype none

package bul_pkg;

   localparam int CAPACITY = 64;
   localparam int SLOTS    = 64;
   localparam int ADDR_W   = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int DATA_W   = 32;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [DATA_W-1:0] word_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_DUMP   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_EMPTY     = 3'd5,
      ST_LISTED    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_SHIFT,
      SEQ_DUMP,
      SEQ_RESP
   } seq_state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] element;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } ram_req_type;

   typedef struct packed {
      count_type count;
      logic      busy;
   } seq_stat_type;

endpackage

`default_nettype wire

// File: hdl/bul_ram.sv
// list storage: one write port, one registered read port
`default_nettype none

module bul_ram
   import bul_pkg::*;
(
   input  wire logic        clock,
   input  wire ram_req_type ram_req,
   output word_type         rd_data
);

   word_type mem [SLOTS];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      // read data holds until the next read
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/bul_seq.sv
// sequencer: search, shift and dump walks over the list memory, result register
`default_nettype none

module bul_seq
   import bul_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   output ram_req_type  ram_req,
   input  wire word_type ram_rd_data,
   output seq_stat_type stat
);

   seq_state_type state_ff, state_in;
   addr_type      idx_ff, idx_in;
   addr_type      head_ff, head_in;
   count_type     count_ff, count_in;
   logic          insert_ff, insert_in;
   word_type      value_ff, value_in;
   status_type    pend_status_ff, pend_status_in;
   word_type      pend_elem_ff, pend_elem_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          out_free;
   logic          load;
   rsp_type       load_data;
   logic          hit;
   logic          at_end;
   logic          shift_end;
   addr_type      cur_addr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit       = ram_rd_data == value_ff;
   // list front sits at head, so logical slot i lives at head + i
   assign cur_addr  = head_ff + idx_ff;
   assign at_end    = ({1'b0, idx_ff} + count_type'(1)) == count_ff;
   assign shift_end = ({1'b0, idx_ff} + count_type'(2)) == count_ff;
   assign req_stall = state_ff != SEQ_IDLE;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      insert_in      = insert_ff;
      value_in       = value_ff;
      pend_status_in = pend_status_ff;
      pend_elem_in   = pend_elem_ff;
      ram_req        = '0;
      load           = 1'b0;
      load_data      = '0;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               value_in     = word_type'(req_data.value);
               pend_elem_in = word_type'(req_data.value);
               idx_in       = '0;
               unique case (req_data.kind)
                  KIND_INSERT: begin
                     insert_in = 1'b1;
                     priority if (count_ff >= count_type'(CAPACITY)) begin
                        pend_status_in = ST_FULL;
                        state_in       = SEQ_RESP;
                     end else if (count_ff == '0) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = head_ff - addr_type'(1);
                        ram_req.wr_data = word_type'(req_data.value);
                        head_in         = head_ff - addr_type'(1);
                        count_in        = count_ff + count_type'(1);
                        pend_status_in  = ST_INSERTED;
                        state_in        = SEQ_RESP;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = head_ff;
                        state_in        = SEQ_SCAN;
                     end
                  end
                  KIND_REMOVE: begin
                     insert_in = 1'b0;
                     if (count_ff == '0) begin
                        pend_status_in = ST_EMPTY;
                        state_in       = SEQ_RESP;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = head_ff;
                        state_in        = SEQ_SCAN;
                     end
                  end
                  KIND_DUMP: begin
                     insert_in = 1'b0;
                     if (count_ff == '0) begin
                        pend_status_in = ST_EMPTY;
                        pend_elem_in   = '0;
                        state_in       = SEQ_RESP;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = head_ff;
                        state_in        = SEQ_DUMP;
                     end
                  end
                  default: begin
                     // unused kind: taken and dropped
                     insert_in = 1'b0;
                  end
               endcase
            end
         end

         SEQ_SCAN: begin
            priority if (hit) begin
               if (insert_ff) begin
                  pend_status_in = ST_DUPLICATE;
                  state_in       = SEQ_RESP;
               end else if (at_end) begin
                  count_in       = count_ff - count_type'(1);
                  pend_status_in = ST_REMOVED;
                  state_in       = SEQ_RESP;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = cur_addr + addr_type'(1);
                  state_in        = SEQ_SHIFT;
               end
            end else if (at_end) begin
               if (insert_ff) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = head_ff - addr_type'(1);
                  ram_req.wr_data = value_ff;
                  head_in         = head_ff - addr_type'(1);
                  count_in        = count_ff + count_type'(1);
                  pend_status_in  = ST_INSERTED;
               end else begin
                  pend_status_in = ST_NOT_FOUND;
               end
               state_in = SEQ_RESP;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = cur_addr + addr_type'(1);
               idx_in          = idx_ff + addr_type'(1);
            end
         end

         SEQ_SHIFT: begin
            // read data is slot idx + 1, moved down into slot idx
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cur_addr;
            ram_req.wr_data = ram_rd_data;
            if (shift_end) begin
               count_in       = count_ff - count_type'(1);
               pend_status_in = ST_REMOVED;
               state_in       = SEQ_RESP;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = cur_addr + addr_type'(2);
               idx_in          = idx_ff + addr_type'(1);
            end
         end

         SEQ_DUMP: begin
            if (out_free) begin
               load              = 1'b1;
               load_data.status  = ST_LISTED;
               load_data.element = ram_rd_data;
               load_data.last    = at_end;
               if (at_end) begin
                  state_in = SEQ_IDLE;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = cur_addr + addr_type'(1);
                  idx_in          = idx_ff + addr_type'(1);
               end
            end
         end

         SEQ_RESP: begin
            if (out_free) begin
               load              = 1'b1;
               load_data.status  = pend_status_ff;
               load_data.element = pend_elem_ff;
               load_data.last    = 1'b1;
               state_in          = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      insert_ff      <= insert_in;
      value_ff       <= value_in;
      pend_status_ff <= pend_status_in;
      pend_elem_ff   <= pend_elem_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign stat.count = count_ff;
   assign stat.busy  = state_ff != SEQ_IDLE;

endmodule

`default_nettype wire

// File: hdl/bounded_unique_list.sv
// bounded unique list: insert at front, remove by value, dump in order
// insert searches the list for a duplicate before writing at the front; a remove shifts the
//   entries after the match down to close the gap; dump gives one beat a cycle while rsp_stall is low
// every walk goes through the single read port of the list memory; requests are taken
//   only while the sequencer is idle
// reset clears the fill count and front pointer at once; the memory has no clearing pass
`default_nettype none

module bounded_unique_list
   import bul_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   ram_req_type  ram_req;
   word_type     ram_rd_data;
   seq_stat_type stat;

   bul_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .stat        (stat)
   );

   bul_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= count_type'(CAPACITY))
      else $error("fill count above capacity");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
      else $error("memory read and write hit the same entry");

   a_mid_beat_listed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.status == ST_LISTED))
      else $error("non-final beat that is not a listed element");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      (ram_req.wr_en && !stat.busy) |-> (stat.count == '0))
      else $error("memory written from idle with a non-empty list");
`endif

endmodule

`default_nettype wire
